>>> hdl/npcm_pkg.sv
package npcm_pkg;

  localparam int TABLE_SIZE    = 64;
  localparam int PAL_ENTRIES   = 64;
  localparam int SMALL_ENTRIES = 16;
  localparam int IDX_W         = 6;
  localparam int CH_W          = 8;
  localparam int SQ_W          = 2 * CH_W;
  localparam int DIST_W        = SQ_W + 2;
  localparam int NUM_LVLS      = 4;
  localparam int NUM_CH        = 3;
  localparam int CFG_W         = 24;
  localparam int CFG_IDX_W     = 2;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_PALETTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ENABLE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR     = 2'd2;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [1:0]      QUANT_OPAQUE = 2'd3;

  // palette entry as 2-bit level codes: ch0 in [1:0], ch1 in [3:2], ch2 in [5:4]
  // a code also equals the 2-bit quantization of its channel level
  typedef logic [5:0] pal_code_t;

  localparam pal_code_t PAL_CODES [TABLE_SIZE] = '{
    6'd0,  6'd2,  6'd8,  6'd10, 6'd32, 6'd34, 6'd40, 6'd42,
    6'd21, 6'd3,  6'd12, 6'd15, 6'd48, 6'd51, 6'd60, 6'd63,
    6'd16, 6'd4,  6'd20, 6'd36, 6'd52, 6'd24, 6'd56, 6'd28,
    6'd44, 6'd1,  6'd17, 6'd33, 6'd49, 6'd5,  6'd37, 6'd53,
    6'd9,  6'd25, 6'd41, 6'd57, 6'd13, 6'd29, 6'd45, 6'd61,
    6'd18, 6'd50, 6'd6,  6'd22, 6'd38, 6'd54, 6'd26, 6'd58,
    6'd14, 6'd30, 6'd46, 6'd62, 6'd19, 6'd35, 6'd7,  6'd23,
    6'd39, 6'd55, 6'd11, 6'd27, 6'd43, 6'd59, 6'd31, 6'd47
  };

  typedef struct packed {
    logic valid;
    logic blank;
    logic short_pal;
  } npcm_ctl_t;

  typedef struct packed {
    logic [DIST_W-1:0] sq_sum;
    logic [IDX_W-1:0]  idx;
  } npcm_cand_t;

  function automatic logic [CH_W-1:0] lvl_value(input logic [1:0] code);
    logic [CH_W-1:0] v;
    case (code)
      2'd0:    v = 8'd0;
      2'd1:    v = 8'd85;
      2'd2:    v = 8'd170;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  // a is the lower index: b wins only with a strictly smaller distance
  function automatic npcm_cand_t cand_pick(input npcm_cand_t a, input npcm_cand_t b);
    return (b.sq_sum < a.sq_sum) ? b : a;
  endfunction

endpackage

>>> hdl/nearest_palette_color_mapper_unit.sv
// nearest palette color mapper: one rgba pixel to the nearest of 64 (or 16) colors
// a request taken with start passes the square, distance sum, two tree stage and output
//   registers in turn, and its result shows with out_valid high
// throughput: one request per clock, busy is never raised; the receiver cannot stall
// reset (rst_n low, synchronous): pipeline emptied, all config registers cleared
module nearest_palette_color_mapper_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // request side
  input  logic                             start,
  output logic                             busy,
  input  logic [npcm_pkg::CH_W-1:0]        in_chan_zero,
  input  logic [npcm_pkg::CH_W-1:0]        in_chan_one,
  input  logic [npcm_pkg::CH_W-1:0]        in_chan_two,
  input  logic [npcm_pkg::CH_W-1:0]        in_alpha_in,
  // config write port
  input  logic                             cfg_we,
  input  logic [npcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [npcm_pkg::CFG_W-1:0]       cfg_data,
  // result side
  output logic                             out_valid,
  output logic [npcm_pkg::CH_W-1:0]        out_zero,
  output logic [npcm_pkg::CH_W-1:0]        out_one,
  output logic [npcm_pkg::CH_W-1:0]        out_two,
  output logic [npcm_pkg::CH_W-1:0]        out_alpha_out,
  output logic [npcm_pkg::IDX_W-1:0]       out_color_index,
  output logic [npcm_pkg::CH_W-1:0]        out_packed_byte
);

  // config registers
  logic                       small_palette_r;
  logic                       key_enable_r;
  logic [npcm_pkg::CFG_W-1:0] key_color_r;

  // request classification
  logic                       keyed;
  npcm_pkg::npcm_ctl_t        in_ctl;

  // search pipeline outputs
  npcm_pkg::npcm_ctl_t        srch_ctl;
  logic [npcm_pkg::IDX_W-1:0] srch_idx;
  npcm_pkg::pal_code_t        srch_code;

  // output register
  logic                       out_valid_r;
  logic [npcm_pkg::CH_W-1:0]  out_zero_r, out_zero_nxt;
  logic [npcm_pkg::CH_W-1:0]  out_one_r, out_one_nxt;
  logic [npcm_pkg::CH_W-1:0]  out_two_r, out_two_nxt;
  logic [npcm_pkg::CH_W-1:0]  out_alpha_r, out_alpha_nxt;
  logic [npcm_pkg::IDX_W-1:0] out_index_r, out_index_nxt;
  logic [npcm_pkg::CH_W-1:0]  out_packed_r, out_packed_nxt;

  // every cycle can take a request: the pipeline never stalls
  assign busy = 1'b0;

  // register writes; index 3 falls through and is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      small_palette_r <= 1'b0;
      key_enable_r    <= 1'b0;
      key_color_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        npcm_pkg::REG_SMALL_PALETTE: small_palette_r <= cfg_data[0];
        npcm_pkg::REG_KEY_ENABLE:    key_enable_r    <= cfg_data[0];
        npcm_pkg::REG_KEY_COLOR:     key_color_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // key match ignores alpha; either key match or zero alpha blanks the pixel
  assign keyed = key_enable_r &&
                 in_chan_zero == key_color_r[7:0] &&
                 in_chan_one  == key_color_r[15:8] &&
                 in_chan_two  == key_color_r[23:16];

  assign in_ctl.valid     = start && !busy;
  assign in_ctl.blank     = keyed || (in_alpha_in == '0);
  assign in_ctl.short_pal = small_palette_r;

  // squares, 64 distance sums and the min tree (lowest index wins ties)
  npcm_search u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (in_ctl),
    .in_ch0  (in_chan_zero),
    .in_ch1  (in_chan_one),
    .in_ch2  (in_chan_two),
    .out_ctl (srch_ctl),
    .out_idx (srch_idx)
  );

  assign srch_code = npcm_pkg::PAL_CODES[srch_idx];

  // result formatting: blank pixels give transparent black
  always_comb begin
    if (srch_ctl.blank) begin
      out_zero_nxt   = '0;
      out_one_nxt    = '0;
      out_two_nxt    = '0;
      out_alpha_nxt  = '0;
      out_index_nxt  = '0;
      out_packed_nxt = '0;
    end else begin
      out_zero_nxt   = npcm_pkg::lvl_value(srch_code[1:0]);
      out_one_nxt    = npcm_pkg::lvl_value(srch_code[3:2]);
      out_two_nxt    = npcm_pkg::lvl_value(srch_code[5:4]);
      out_alpha_nxt  = npcm_pkg::ALPHA_OPAQUE;
      out_index_nxt  = srch_idx;
      // level codes are already the 2-bit quantized channels
      out_packed_nxt = {npcm_pkg::QUANT_OPAQUE, srch_code[1:0], srch_code[3:2],
                        srch_code[5:4]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= srch_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_zero_r   <= out_zero_nxt;
    out_one_r    <= out_one_nxt;
    out_two_r    <= out_two_nxt;
    out_alpha_r  <= out_alpha_nxt;
    out_index_r  <= out_index_nxt;
    out_packed_r <= out_packed_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_zero        = out_zero_r;
  assign out_one         = out_one_r;
  assign out_two         = out_two_r;
  assign out_alpha_out   = out_alpha_r;
  assign out_color_index = out_index_r;
  assign out_packed_byte = out_packed_r;

endmodule

>>> hdl/npcm_search.sv
module npcm_search (
  input  logic                        clk,
  input  logic                        rst_n,
  input  npcm_pkg::npcm_ctl_t         in_ctl,
  input  logic [npcm_pkg::CH_W-1:0]   in_ch0,
  input  logic [npcm_pkg::CH_W-1:0]   in_ch1,
  input  logic [npcm_pkg::CH_W-1:0]   in_ch2,
  output npcm_pkg::npcm_ctl_t         out_ctl,
  output logic [npcm_pkg::IDX_W-1:0]  out_idx
);

  localparam int N1 = npcm_pkg::TABLE_SIZE / 2;
  localparam int N2 = N1 / 4;
  localparam int N3 = N2 / 4;

  logic [npcm_pkg::CH_W-1:0] ch [npcm_pkg::NUM_CH];
  logic [npcm_pkg::SQ_W-1:0] sq_nxt [npcm_pkg::NUM_CH][npcm_pkg::NUM_LVLS];
  logic [npcm_pkg::SQ_W-1:0] sq_r   [npcm_pkg::NUM_CH][npcm_pkg::NUM_LVLS];
  npcm_pkg::npcm_ctl_t       ctl1_r, ctl2_r, ctl3_r, ctl4_r;

  npcm_pkg::npcm_cand_t cand0 [npcm_pkg::TABLE_SIZE];
  npcm_pkg::npcm_cand_t c2_nxt [N1];
  npcm_pkg::npcm_cand_t c2_r   [N1];
  npcm_pkg::npcm_cand_t c3_mid [N1/2];
  npcm_pkg::npcm_cand_t c3_nxt [N2];
  npcm_pkg::npcm_cand_t c3_r   [N2];
  npcm_pkg::npcm_cand_t c4_mid [N2/2];
  npcm_pkg::npcm_cand_t c4_nxt [N3];
  npcm_pkg::npcm_cand_t c4_r   [N3];
  npcm_pkg::npcm_cand_t best;

  assign ch[0] = in_ch0;
  assign ch[1] = in_ch1;
  assign ch[2] = in_ch2;

  // stage 1: squared channel distance to each of the four levels
  always_comb begin
    logic [npcm_pkg::CH_W-1:0] lv;
    logic [npcm_pkg::CH_W-1:0] d;
    for (int c = 0; c < npcm_pkg::NUM_CH; c++) begin
      for (int l = 0; l < npcm_pkg::NUM_LVLS; l++) begin
        lv = npcm_pkg::lvl_value(2'(l));
        d  = (ch[c] >= lv) ? (ch[c] - lv) : (lv - ch[c]);
        sq_nxt[c][l] = npcm_pkg::SQ_W'(d) * npcm_pkg::SQ_W'(d);
      end
    end
  end

  // stage 2: per-entry distance, first pairwise pick
  always_comb begin
    npcm_pkg::pal_code_t code;
    for (int e = 0; e < npcm_pkg::TABLE_SIZE; e++) begin
      code = npcm_pkg::PAL_CODES[e];
      cand0[e].sq_sum = npcm_pkg::DIST_W'(sq_r[0][code[1:0]]) +
                        npcm_pkg::DIST_W'(sq_r[1][code[3:2]]) +
                        npcm_pkg::DIST_W'(sq_r[2][code[5:4]]);
      cand0[e].idx    = npcm_pkg::IDX_W'(e);
      if ((ctl1_r.short_pal && e >= npcm_pkg::SMALL_ENTRIES) ||
          e >= npcm_pkg::PAL_ENTRIES) begin
        cand0[e].sq_sum = '1;
      end
    end
    for (int i = 0; i < N1; i++) begin
      c2_nxt[i] = npcm_pkg::cand_pick(cand0[2*i], cand0[2*i+1]);
    end
  end

  // stage 3: two tree levels
  always_comb begin
    for (int i = 0; i < N1/2; i++) begin
      c3_mid[i] = npcm_pkg::cand_pick(c2_r[2*i], c2_r[2*i+1]);
    end
    for (int i = 0; i < N2; i++) begin
      c3_nxt[i] = npcm_pkg::cand_pick(c3_mid[2*i], c3_mid[2*i+1]);
    end
  end

  // stage 4: two tree levels
  always_comb begin
    for (int i = 0; i < N2/2; i++) begin
      c4_mid[i] = npcm_pkg::cand_pick(c3_r[2*i], c3_r[2*i+1]);
    end
    for (int i = 0; i < N3; i++) begin
      c4_nxt[i] = npcm_pkg::cand_pick(c4_mid[2*i], c4_mid[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else begin
      ctl1_r <= in_ctl;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_r <= sq_nxt;
    c2_r <= c2_nxt;
    c3_r <= c3_nxt;
    c4_r <= c4_nxt;
  end

  assign best    = npcm_pkg::cand_pick(c4_r[0], c4_r[1]);
  assign out_idx = best.idx;
  assign out_ctl = ctl4_r;

endmodule
